@@ rtl/core/pce_pkg.sv @@
// Package with shared types, register indexes and bit helpers for the CRC engine.
`timescale 1ns / 1ps

package pce_pkg;

  localparam int CRC_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 3;

  // Width select codes. The unused code is treated as 32 bits.
  localparam logic [1:0] WSEL_16 = 2'd0;
  localparam logic [1:0] WSEL_24 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SELECT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_XOR_IN_VALUE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_XOR_OUT_VALUE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REFIN            = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REFOUT           = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [1:0]       RST_WIDTH_SELECT = WSEL_32;
  localparam logic [CRC_W-1:0] RST_POLYNOMIAL   = 32'h04C1_1DB7;

  typedef struct packed {
    logic [1:0]       width_select;
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] init_value;
    logic [CRC_W-1:0] xor_in_value;
    logic [CRC_W-1:0] xor_out_value;
    logic             refin;
    logic             refout;
  } cfg_t;

  function automatic logic [CRC_W-1:0] width_mask(input logic [1:0] ws);
    logic [CRC_W-1:0] m;
    case (ws)
      WSEL_16: m = 32'h0000_FFFF;
      WSEL_24: m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    return r;
  endfunction

  // Bit reversal over the selected CRC width; the value must already be masked.
  function automatic logic [CRC_W-1:0] rev_width(input logic [CRC_W-1:0] v,
                                                 input logic [1:0] ws);
    logic [CRC_W-1:0] full;
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      full[i] = v[CRC_W-1-i];
    end
    case (ws)
      WSEL_16: r = full >> 16;
      WSEL_24: r = full >> 8;
      default: r = full;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/parametric_crc_engine_core.sv @@
// Top level of the byte-serial CRC engine: handshake, state and result register.
`timescale 1ns / 1ps
// A beat waits in the input register and updates the CRC register when it leaves
// that stage, and a last byte's result loads the output register with it.
// Throughput: one byte per cycle, set by the single eight-bit LFSR update that
// sits between input and CRC/result registers, unless an unread result stalls.
// Reset (rst_n low, synchronous) empties both stages, zeroes the CRC register
// and loads the configuration defaults (CRC-32 polynomial, 32-bit, reflected).

module parametric_crc_engine_core (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pce_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                              in_first_byte,
  input  logic                              in_last_byte,
  input  logic [pce_pkg::CRC_W-1:0]         in_resume_crc,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pce_pkg::CRC_W-1:0]         out_crc_value,

  input  logic                              cfg_we,
  input  logic [pce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pce_pkg::CRC_W-1:0]         cfg_wdata
);

  // Configuration registers. Writes must only happen while the engine is idle;
  // this block does not enforce it; the datapath reads them directly, unshadowed.
  pce_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_select     <= pce_pkg::RST_WIDTH_SELECT;
      cfg_r.polynomial       <= pce_pkg::RST_POLYNOMIAL;
      cfg_r.init_value       <= '0;
      cfg_r.xor_in_value     <= '0;
      cfg_r.xor_out_value    <= '0;
      cfg_r.refin            <= 1'b1;
      cfg_r.refout           <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        pce_pkg::CFG_WIDTH_SELECT:     cfg_r.width_select     <= cfg_wdata[1:0];
        pce_pkg::CFG_POLYNOMIAL:       cfg_r.polynomial       <= cfg_wdata;
        pce_pkg::CFG_INIT_VALUE:       cfg_r.init_value       <= cfg_wdata;
        pce_pkg::CFG_XOR_IN_VALUE:     cfg_r.xor_in_value     <= cfg_wdata;
        pce_pkg::CFG_XOR_OUT_VALUE:    cfg_r.xor_out_value    <= cfg_wdata;
        pce_pkg::CFG_REFIN:            cfg_r.refin            <= cfg_wdata[0];
        pce_pkg::CFG_REFOUT:           cfg_r.refout           <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Input stage. Each accepted beat is captured here; the CRC update is done
  // combinationally from this register and the running CRC register.
  logic                         s1_valid_r;
  logic                         s1_first_r;
  logic                         s1_last_r;
  logic [pce_pkg::BYTE_W-1:0]   s1_data_r;
  logic [pce_pkg::CRC_W-1:0]    s1_resume_r;

  logic [pce_pkg::CRC_W-1:0]    crc_r;
  logic [pce_pkg::CRC_W-1:0]    crc_nxt;
  logic [pce_pkg::CRC_W-1:0]    result_nxt;

  logic                         out_valid_r;
  logic [pce_pkg::CRC_W-1:0]    out_crc_r;

  logic                         s1_adv;
  logic                         in_acc;

  // A beat without last_byte never needs the result register, so it moves on
  // even while a finished CRC waits downstream. A last beat needs the result
  // register to be empty or being drained in this cycle.
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_first_r  <= in_first_byte;
      s1_last_r   <= in_last_byte;
      s1_data_r   <= in_data_byte;
      s1_resume_r <= in_resume_crc;
    end
  end

  pce_step u_step (
    .cfg        (cfg_r),
    .crc_cur    (crc_r),
    .data_byte  (s1_data_r),
    .first_byte (s1_first_r),
    .resume_crc (s1_resume_r),
    .crc_next   (crc_nxt)
  );

  pce_final u_final (
    .cfg       (cfg_r),
    .crc_reg   (crc_nxt),
    .crc_value (result_nxt)
  );

  // The running CRC keeps the pre-reflection value after a message ends, so
  // a following byte without first_byte continues from it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else if (s1_adv) begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_crc_r <= result_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  // A new result only shows up after a last beat left the input stage.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result appeared without a last beat leaving the input stage");

  // The running CRC only moves when a beat is consumed.
  a_crc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(crc_r))
    else $error("CRC register changed without a consumed beat");

  // An empty input stage always takes a beat.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stage empty but not ready");

  // Reset leaves both stages empty.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!s1_valid_r && !out_valid_r))
    else $error("stage still valid after reset");

endmodule

@@ rtl/core/pce_step.sv @@
// Start-of-message selection and the unrolled eight-bit reflected CRC update.
`timescale 1ns / 1ps

module pce_step (
  input  pce_pkg::cfg_t                   cfg,
  input  logic [pce_pkg::CRC_W-1:0]       crc_cur,
  input  logic [pce_pkg::BYTE_W-1:0]      data_byte,
  input  logic                            first_byte,
  input  logic [pce_pkg::CRC_W-1:0]       resume_crc,
  output logic [pce_pkg::CRC_W-1:0]       crc_next
);

  logic [pce_pkg::CRC_W-1:0] mask;
  logic [pce_pkg::CRC_W-1:0] rpoly;
  logic [pce_pkg::CRC_W-1:0] resume_m;
  logic [pce_pkg::CRC_W-1:0] start;
  logic [pce_pkg::BYTE_W-1:0] byte_in;

  assign mask     = pce_pkg::width_mask(cfg.width_select);
  assign rpoly    = pce_pkg::rev_width(cfg.polynomial & mask, cfg.width_select);
  assign resume_m = resume_crc & mask;
  assign byte_in  = cfg.refin ? data_byte : pce_pkg::rev8(data_byte);

  always_comb begin
    if (first_byte) begin
      start = ((resume_m != '0) ? resume_m : (cfg.init_value & mask));
      start = (start ^ cfg.xor_in_value) & mask;
    end else begin
      start = crc_cur & mask;
    end
  end

  // One bit per step, LSB first; rpoly is masked so the register stays in width.
  always_comb begin
    logic [pce_pkg::CRC_W-1:0] r;
    r = start ^ {{(pce_pkg::CRC_W-pce_pkg::BYTE_W){1'b0}}, byte_in};
    for (int i = 0; i < pce_pkg::BYTE_W; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ rpoly;
      end else begin
        r = r >> 1;
      end
    end
    crc_next = r & mask;
  end

endmodule

@@ rtl/core/pce_final.sv @@
// Final reflection and output XOR applied to a finished CRC register.
`timescale 1ns / 1ps

module pce_final (
  input  pce_pkg::cfg_t             cfg,
  input  logic [pce_pkg::CRC_W-1:0] crc_reg,
  output logic [pce_pkg::CRC_W-1:0] crc_value
);

  logic [pce_pkg::CRC_W-1:0] mask;
  logic [pce_pkg::CRC_W-1:0] oriented;

  assign mask      = pce_pkg::width_mask(cfg.width_select);
  assign oriented  = cfg.refout ? crc_reg
                                : pce_pkg::rev_width(crc_reg, cfg.width_select);
  assign crc_value = (oriented ^ cfg.xor_out_value) & mask;

endmodule
